>>> design/chm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chm_pkg: shared constants and types for the chained hash map
// Sizes of the bucket table and node pool, beat layouts, link entries and
// result status codes.
// ----------------------------------------------------------------------------
package chm_pkg;

   // Table sizes; the bucket count is a power of two so the bucket is a key slice
   localparam int unsigned BUCKET_COUNT    = 1024;
   localparam int unsigned NODE_POOL_DEPTH = 1024;

   localparam int unsigned BUCKET_IDX_W = $clog2(BUCKET_COUNT);
   localparam int unsigned NODE_IDX_W   = $clog2(NODE_POOL_DEPTH);
   localparam int unsigned COUNT_W      = $clog2(NODE_POOL_DEPTH + 1);

   // Field widths
   localparam int unsigned KEY_W         = 64;
   localparam int unsigned VALUE_W       = 64;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned ENTRY_COUNT_W = 11;

   // Beat layouts
   localparam int unsigned REQ_TDATA_W   = KEY_W + VALUE_W;
   localparam int unsigned RSP_FIELDS_W  = 1 + VALUE_W + STATUS_W + ENTRY_COUNT_W;
   localparam int unsigned RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Action codes carried on the request tuser
   localparam logic ACTION_LOOKUP = 1'b0;
   localparam logic ACTION_INSERT = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_PRESENT  = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_LOOKUP   = 2'd3
   } status_type;

   // Chain link: bucket head or node next pointer
   typedef struct packed {
      logic                  valid;
      logic [NODE_IDX_W-1:0] idx;
   } link_type;

   // Node payload
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } node_data_type;

endpackage : chm_pkg
`default_nettype wire

>>> design/chained_hash_map_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_map_core: hash map with separate chaining over a node pool
// Lookup or insert of a 64-bit key; walks the bucket chain in node memory
// and appends new nodes at the chain tail.
// ----------------------------------------------------------------------------
// One item is handled at a time. After acceptance the core reads the bucket
// head (ST_HEAD) and walks the chain node by node (ST_NODE). An insert that
// misses with room in the pool writes the new node (ST_ALLOC) and, if the
// bucket already holds a chain, hooks it behind the tail (ST_LINK); every
// item ends with a reply (ST_REPLY). Each chain hop costs one read of the
// node memories, which are read through a register. The result beat waits in
// an output register, so a new request is taken while it is still pending.
// After reset the bucket table is cleared one entry per cycle, during which
// req_tready stays low. Bucket is key modulo BUCKET_COUNT; nodes are allocated in order and never freed.
module chained_hash_map_core
   import chm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // key[63:0], value[127:64]
   input  wire logic                   req_tuser,   // action[0]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata    // found[0], stored_value[64:1],
                                                    // insert_status[66:65],
                                                    // entry_count[77:67], zero pad
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_NODE,
      ST_ALLOC,
      ST_LINK,
      ST_REPLY
   } state_type;

   // Control state
   state_type                state_ff,     state_in;
   logic [BUCKET_IDX_W-1:0]  clr_idx_ff,   clr_idx_in;
   logic [COUNT_W-1:0]       count_ff,     count_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Item payload and walk context
   logic                     action_ff,    action_in;
   logic [KEY_W-1:0]         key_ff,       key_in;
   logic [VALUE_W-1:0]       value_ff,     value_in;
   logic [NODE_IDX_W-1:0]    cur_ff,       cur_in;
   logic                     has_tail_ff,  has_tail_in;
   logic                     found_ff,     found_in;
   logic [VALUE_W-1:0]       hit_value_ff, hit_value_in;
   status_type               status_ff,    status_in;
   logic [NODE_IDX_W-1:0]    new_idx_ff,   new_idx_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff,  rsp_data_in;

   // Memories and their ports
   link_type                 head_mem [BUCKET_COUNT];
   link_type                 head_rd_ff;
   logic                     head_we;
   logic [BUCKET_IDX_W-1:0]  head_waddr;
   link_type                 head_wdata;
   logic [BUCKET_IDX_W-1:0]  head_raddr;

   node_data_type            data_mem [NODE_POOL_DEPTH];
   node_data_type            data_rd_ff;
   logic                     data_we;
   node_data_type            data_wdata;

   link_type                 link_mem [NODE_POOL_DEPTH];
   link_type                 link_rd_ff;
   logic                     link_we;
   logic [NODE_IDX_W-1:0]    link_waddr;
   link_type                 link_wdata;

   logic [NODE_IDX_W-1:0]    node_raddr;
   logic [NODE_IDX_W-1:0]    alloc_idx;
   logic [BUCKET_IDX_W-1:0]  bucket;

   // Outcome of a walk that found no equal key
   state_type                miss_state;
   status_type               miss_status;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign alloc_idx  = count_ff[NODE_IDX_W-1:0];
   assign bucket     = key_ff[BUCKET_IDX_W-1:0];
   assign head_raddr = req_tdata[BUCKET_IDX_W-1:0];

   // Resolve a miss: report lookup, report pool full, or go allocate
   always_comb begin
      priority if (action_ff != ACTION_INSERT) begin
         miss_state  = ST_REPLY;
         miss_status = STATUS_LOOKUP;
      end else if (count_ff == COUNT_W'(NODE_POOL_DEPTH)) begin
         miss_state  = ST_REPLY;
         miss_status = STATUS_FULL;
      end else begin
         miss_state  = ST_ALLOC;
         miss_status = STATUS_INSERTED;
      end
   end

   // Sequencer: clear, accept, walk, allocate, link, reply
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      cur_in       = cur_ff;
      has_tail_in  = has_tail_ff;
      found_in     = found_ff;
      hit_value_in = hit_value_ff;
      status_in    = status_ff;
      new_idx_in   = new_idx_ff;
      rsp_data_in  = rsp_data_ff;

      head_we      = 1'b0;
      head_waddr   = bucket;
      head_wdata   = '{valid: 1'b1, idx: alloc_idx};
      data_we      = 1'b0;
      data_wdata   = '{key: key_ff, value: value_ff};
      link_we      = 1'b0;
      link_waddr   = alloc_idx;
      link_wdata   = '{valid: 1'b0, idx: '0};
      node_raddr   = cur_ff;

      // Drop the result beat once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_idx_ff;
            head_wdata = '{valid: 1'b0, idx: '0};
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == BUCKET_IDX_W'(BUCKET_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in    = req_tuser;
               key_in       = req_tdata[KEY_W-1:0];
               value_in     = req_tdata[KEY_W +: VALUE_W];
               has_tail_in  = 1'b0;
               found_in     = 1'b0;
               hit_value_in = '0;
               state_in     = ST_HEAD;
            end
         end
         ST_HEAD: begin
            // Follow the head if it points at an allocated node
            if (head_rd_ff.valid && (COUNT_W'(head_rd_ff.idx) < count_ff)) begin
               node_raddr = head_rd_ff.idx;
               cur_in     = head_rd_ff.idx;
               state_in   = ST_NODE;
            end else begin
               status_in = miss_status;
               state_in  = miss_state;
            end
         end
         ST_NODE: begin
            if (data_rd_ff.key == key_ff) begin
               found_in     = 1'b1;
               hit_value_in = data_rd_ff.value;
               status_in    = (action_ff == ACTION_INSERT) ? STATUS_PRESENT : STATUS_LOOKUP;
               state_in     = ST_REPLY;
            end else begin
               // Current node becomes the tail unless the chain goes on
               has_tail_in = 1'b1;
               if (link_rd_ff.valid && (COUNT_W'(link_rd_ff.idx) < count_ff)) begin
                  node_raddr = link_rd_ff.idx;
                  cur_in     = link_rd_ff.idx;
               end else begin
                  status_in = miss_status;
                  state_in  = miss_state;
               end
            end
         end
         ST_ALLOC: begin
            // Write the new node; an empty bucket gets it as head
            data_we    = 1'b1;
            link_we    = 1'b1;
            head_we    = !has_tail_ff;
            new_idx_in = alloc_idx;
            count_in   = count_ff + 1'b1;
            state_in   = has_tail_ff ? ST_LINK : ST_REPLY;
         end
         ST_LINK: begin
            // Hook the new node behind the chain tail
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = '{valid: 1'b1, idx: new_idx_ff};
            state_in   = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}},
                               ENTRY_COUNT_W'(count_ff),
                               status_ff,
                               hit_value_ff,
                               found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      cur_ff       <= cur_in;
      has_tail_ff  <= has_tail_in;
      found_ff     <= found_in;
      hit_value_ff <= hit_value_in;
      status_ff    <= status_in;
      new_idx_ff   <= new_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Bucket head table
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[head_raddr];
   end

   // Node key and value store
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[alloc_idx] <= data_wdata;
      end
      data_rd_ff <= data_mem[node_raddr];
   end

   // Node next-pointer store
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[node_raddr];
   end

`ifndef SYNTHESIS
   // Entry count never passes the pool size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(NODE_POOL_DEPTH))
      else $error("entry count above pool depth");

   // Entry count changes only by an allocation
   a_count_alloc: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> $past(state_ff == ST_ALLOC))
      else $error("entry count changed outside allocation");

   // A walked node is always an allocated one
   a_walk_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NODE) |-> (COUNT_W'(cur_ff) < count_ff))
      else $error("chain walk reached an unallocated node");

   // A found key reports present or lookup, never an allocation outcome
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |->
         ((rsp_data_ff[VALUE_W + STATUS_W:VALUE_W + 1] == STATUS_PRESENT) ||
          (rsp_data_ff[VALUE_W + STATUS_W:VALUE_W + 1] == STATUS_LOOKUP)))
      else $error("found result with allocation status");
`endif

endmodule : chained_hash_map_core
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for chained_hash_map_core
// Drives lookup and insert beats with random gaps, keeps a shadow hash map
// with its own chains and node pool, and checks every reply beat field by
// field. Covers empty and chained buckets, zero and all-ones keys and values,
// duplicate inserts, a full node pool, and a long reply back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import chm_pkg::*;

   localparam int unsigned RANDOM_ITEMS     = 800;
   localparam int unsigned FULL_POOL_ITEMS  = 40;
   localparam int unsigned HOLDOFF_CYCLES   = 400;
   localparam int unsigned DRAIN_CYCLES     = 20;
   localparam int unsigned RUN_LIMIT_CYCLES = 3_000_000;
   localparam int unsigned CLOCK_PERIOD     = 4;

   // One reply beat, unpacked into its fields
   typedef struct packed {
      logic                     found;
      logic [VALUE_W-1:0]       stored_value;
      status_type               status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } reply_type;

   // One directed request; the reply fields count only where given is set
   typedef struct packed {
      logic                     act;
      logic [KEY_W-1:0]         key;
      logic [VALUE_W-1:0]       value;
      logic                     given;
      logic                     found;
      logic [VALUE_W-1:0]       stored_value;
      status_type               status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } directed_row_type;

   // Columns: action, key, value, given, found, stored value, status, count
   localparam directed_row_type DIRECTED_ROWS [18] = '{
      // lookup on an empty map, then a zero key with a zero value
      '{ACTION_LOOKUP, '0, '0, 1'b1, 1'b0, '0, STATUS_LOOKUP, 11'd0},
      '{ACTION_INSERT, '0, '0, 1'b1, 1'b0, '0, STATUS_INSERTED, 11'd1},
      '{ACTION_LOOKUP, '0, '0, 1'b1, 1'b1, '0, STATUS_LOOKUP, 11'd1},
      // duplicate insert keeps the old value
      '{ACTION_INSERT, '0, '1, 1'b1, 1'b1, '0, STATUS_PRESENT, 11'd1},
      // all-ones key and value land in the last bucket
      '{ACTION_INSERT, '1, '1, 1'b1, 1'b0, '0, STATUS_INSERTED, 11'd2},
      '{ACTION_LOOKUP, '1, '0, 1'b1, 1'b1, '1, STATUS_LOOKUP, 11'd2},
      // grow a chain in bucket zero
      '{ACTION_INSERT, 64'h400, 64'h5555_5555_5555_5555,
        1'b1, 1'b0, '0, STATUS_INSERTED, 11'd3},
      '{ACTION_INSERT, 64'h800, 64'hAAAA_AAAA_AAAA_AAAA,
        1'b1, 1'b0, '0, STATUS_INSERTED, 11'd4},
      '{ACTION_LOOKUP, 64'h800, '0,
        1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, STATUS_LOOKUP, 11'd4},
      '{ACTION_LOOKUP, 64'hC00, '0, 1'b1, 1'b0, '0, STATUS_LOOKUP, 11'd4},
      '{ACTION_INSERT, 64'h400, 64'h1234,
        1'b1, 1'b1, 64'h5555_5555_5555_5555, STATUS_PRESENT, 11'd4},
      '{ACTION_INSERT, 64'hFFFF_FFFF_FFFF_FC00, 64'h8000_0000_0000_0001,
        1'b0, 1'b0, '0, STATUS_INSERTED, '0},
      '{ACTION_LOOKUP, 64'h8000_0000_0000_0000, '0,
        1'b1, 1'b0, '0, STATUS_LOOKUP, 11'd5},
      // chain behind the all-ones key
      '{ACTION_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1,
        1'b1, 1'b0, '0, STATUS_INSERTED, 11'd6},
      '{ACTION_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0,
        1'b1, 1'b1, 64'h1, STATUS_LOOKUP, 11'd6},
      '{ACTION_LOOKUP, 64'h1, '0, 1'b1, 1'b0, '0, STATUS_LOOKUP, 11'd6},
      '{ACTION_LOOKUP, 64'hFFFF_FFFF_FFFF_FC00, '1,
        1'b0, 1'b0, '0, STATUS_LOOKUP, '0},
      '{ACTION_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        1'b0, 1'b0, '0, STATUS_INSERTED, '0}
   };

   // Buckets that collect long chains
   localparam logic [BUCKET_IDX_W-1:0] HOT_BUCKETS [8] = '{
      10'd0, 10'd1, 10'd2, 10'd3, 10'd511, 10'd512, 10'd1020, 10'd1023
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // key[63:0], value[127:64]
   logic                   req_tuser;   // action[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // found[0], stored_value[64:1],
                                        // insert_status[66:65],
                                        // entry_count[77:67], zero pad

   // Shadow hash map
   link_type               shadow_head  [BUCKET_COUNT];
   logic [KEY_W-1:0]       shadow_key   [NODE_POOL_DEPTH];
   logic [VALUE_W-1:0]     shadow_value [NODE_POOL_DEPTH];
   link_type               shadow_next  [NODE_POOL_DEPTH];
   logic [COUNT_W-1:0]     shadow_entries;
   logic [KEY_W-1:0]       stored_keys [$];

   reply_type              expected_replies [$];
   int unsigned            mismatches;
   bit                     steady;
   bit                     holdoff_wanted;

   chained_hash_map_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_CYCLES * CLOCK_PERIOD);
      $display("** chained_hash_map_core: FAILED **");
      $finish;
   end

   // Walk the bucket chain, then apply a lookup or an insert to the shadow map
   function automatic reply_type lookup_or_insert(input logic act,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [VALUE_W-1:0] v);
      logic [BUCKET_IDX_W-1:0] bkt;
      logic [NODE_IDX_W-1:0]   idx;
      logic [NODE_IDX_W-1:0]   hit;
      logic [NODE_IDX_W-1:0]   tail;
      logic [NODE_IDX_W-1:0]   slot;
      logic                    hit_ok;
      logic                    has_tail;
      logic                    walking;
      int unsigned             steps;
      reply_type               r;
      bkt      = BUCKET_IDX_W'(k % 64'(BUCKET_COUNT));
      hit      = '0;
      tail     = '0;
      hit_ok   = 1'b0;
      has_tail = 1'b0;
      walking  = shadow_head[bkt].valid;
      idx      = shadow_head[bkt].idx;
      steps    = 0;
      // stop at a match, at the chain end, or at a node not yet handed out
      while (walking && steps < NODE_POOL_DEPTH) begin
         if (COUNT_W'(idx) >= shadow_entries) begin
            walking = 1'b0;
         end else if (shadow_key[idx] == k) begin
            hit_ok  = 1'b1;
            hit     = idx;
            walking = 1'b0;
         end else begin
            tail     = idx;
            has_tail = 1'b1;
            if (!shadow_next[idx].valid) walking = 1'b0;
            else idx = shadow_next[idx].idx;
         end
         steps++;
      end

      r.found        = hit_ok;
      r.stored_value = hit_ok ? shadow_value[hit] : '0;
      if (act == ACTION_LOOKUP) begin
         r.status = STATUS_LOOKUP;
      end else if (hit_ok) begin
         r.status = STATUS_PRESENT;
      end else if (shadow_entries >= COUNT_W'(NODE_POOL_DEPTH)) begin
         r.status = STATUS_FULL;
      end else begin
         // append the next free node at the chain tail
         slot               = shadow_entries[NODE_IDX_W-1:0];
         shadow_key[slot]   = k;
         shadow_value[slot] = v;
         shadow_next[slot]  = '{valid: 1'b0, idx: '0};
         if (has_tail) shadow_next[tail] = '{valid: 1'b1, idx: slot};
         else shadow_head[bkt] = '{valid: 1'b1, idx: slot};
         shadow_entries = shadow_entries + 1'b1;
         stored_keys.push_back(k);
         r.status = STATUS_INSERTED;
      end
      r.entry_count = ENTRY_COUNT_W'(shadow_entries);
      return r;
   endfunction

   // Pick a stored key, a fresh key in a hot bucket, or a fully random key
   function automatic logic [KEY_W-1:0] pick_key(input int unsigned known_pct,
                                                  input int unsigned hot_pct);
      logic [KEY_W-1:0] k;
      int unsigned      roll;
      roll = $urandom_range(99);
      k    = {$urandom, $urandom};
      if (roll < known_pct && stored_keys.size() != 0)
         k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      else if (roll < known_pct + hot_pct)
         k[BUCKET_IDX_W-1:0] = HOT_BUCKETS[$urandom_range(7)];
      return k;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(19))
         0:       v = '0;
         1:       v = '1;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Offer one request beat from a falling edge; hold it until taken
   task automatic send_request(input logic act, input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v, input bit given,
                               input reply_type given_reply);
      reply_type predicted;
      while (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, k};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      predicted = lookup_or_insert(act, k, v);
      expected_replies.push_back(given ? given_reply : predicted);
      @(negedge clock);
   endtask

   // Reply side: random stalls, plus one long hold-off to back up the core
   initial begin : reply_stalls
      int unsigned hold_left;
      bit          hold_started;
      hold_left    = 0;
      hold_started = 1'b0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_wanted && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = HOLDOFF_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= steady || $urandom_range(99) >= 24;
         end
      end
   end

   // Compare each accepted reply beat with the oldest expectation
   always @(posedge clock) begin : check_replies
      reply_type got;
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found        = rsp_tdata[0];
         got.stored_value = rsp_tdata[64:1];
         got.status       = status_type'(rsp_tdata[66:65]);
         got.entry_count  = rsp_tdata[77:67];
         if (expected_replies.size() == 0) begin
            $display("%0t: reply with none expected, actual tdata %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = expected_replies.pop_front();
            if (got.found !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
               mismatches++;
            end
            if (got.stored_value !== want.stored_value) begin
               $display("%0t: stored_value expected %h actual %h",
                        $time, want.stored_value, got.stored_value);
               mismatches++;
            end
            if (got.status !== want.status) begin
               $display("%0t: insert_status expected %0d actual %0d",
                        $time, want.status, got.status);
               mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, got.entry_count);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      reply_type        row_reply;
      directed_row_type row;
      logic [KEY_W-1:0] k;
      logic             act;
      int unsigned      n;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = ACTION_LOOKUP;
      mismatches     = 0;
      steady         = 1'b0;
      holdoff_wanted = 1'b0;
      shadow_entries = '0;
      for (n = 0; n < BUCKET_COUNT; n++) shadow_head[n] = '{valid: 1'b0, idx: '0};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (DIRECTED_ROWS[i]) begin
         row                    = DIRECTED_ROWS[i];
         row_reply.found        = row.found;
         row_reply.stored_value = row.stored_value;
         row_reply.status       = row.status;
         row_reply.entry_count  = row.entry_count;
         send_request(row.act, row.key, row.value, row.given, row_reply);
      end

      // Random mix of lookups and inserts over hot and spread buckets
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 300 && n < 420);
         if (n == 550) holdoff_wanted = 1'b1;
         act = $urandom_range(1) ? ACTION_INSERT : ACTION_LOOKUP;
         send_request(act, pick_key(40, 30), pick_value(), 1'b0, row_reply);
      end

      // Fill the node pool to the last node
      while (shadow_entries < COUNT_W'(NODE_POOL_DEPTH))
         send_request(ACTION_INSERT, pick_key(0, 20), pick_value(), 1'b0, row_reply);

      // Full pool: fresh inserts are refused, stored keys still answer
      for (n = 0; n < FULL_POOL_ITEMS; n++) begin
         act = $urandom_range(1) ? ACTION_INSERT : ACTION_LOOKUP;
         k   = pick_key(50, 20);
         send_request(act, k, pick_value(), 1'b0, row_reply);
      end
      req_tvalid <= 1'b0;

      // Drain outstanding replies, then let the core settle
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** chained_hash_map_core: PASSED **");
      end else begin
         $display("** chained_hash_map_core: FAILED **");
      end
      $finish;
   end

endmodule : tb_top
`default_nettype wire
